### hdl/ialt_pkg.sv
// Shared types and constants for the IPv4 allow list table.
`default_nettype none

package ialt_pkg;

    // Default table depth.
    localparam int unsigned MAX_ENTRIES_DEF = 16;

    // Fixed widths of the request and response fields.
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned EIDX_W   = 4;
    localparam int unsigned ECNT_W   = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_QUERY  = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_INVALID   = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_MISS,
        S_RESP
    } t_state;

    // One response as handed from the sequencer to the output stage.
    typedef struct packed {
        logic [ECNT_W-1:0] entry_count;
        logic              allowed;
        logic [EIDX_W-1:0] entry_index;
        t_status           status;
    } t_result;

endpackage

`default_nettype wire

### hdl/ialt_entry_ram.sv
// Address entry memory: one write port, one read port, registered read data.
`default_nettype none

module ialt_entry_ram #(
    parameter int unsigned DEPTH  = ialt_pkg::MAX_ENTRIES_DEF,
    parameter int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [AW-1:0]               i_waddr,
    input  wire logic [ialt_pkg::ADDR_W-1:0] i_wdata,
    input  wire logic [AW-1:0]               i_raddr,
    output logic      [ialt_pkg::ADDR_W-1:0] o_rdata
);

    logic [ialt_pkg::ADDR_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/ialt_seq.sv
// Sequencer: walks the entry memory to search, append and compact the list.
`default_nettype none

module ialt_seq #(
    parameter int unsigned MAX_ENTRIES = ialt_pkg::MAX_ENTRIES_DEF,
    parameter int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    parameter int unsigned CW = $clog2(MAX_ENTRIES + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // request side
    input  wire logic                        i_req_valid,
    output logic                             o_req_ready,
    input  wire ialt_pkg::t_action           i_req_action,
    input  wire logic [ialt_pkg::ADDR_W-1:0] i_req_addr,
    // response side
    output logic                             o_res_valid,
    input  wire logic                        i_res_take,
    output ialt_pkg::t_result                o_res,
    // entry memory
    output logic                             o_mem_we,
    output logic      [IW-1:0]               o_mem_waddr,
    output logic      [ialt_pkg::ADDR_W-1:0] o_mem_wdata,
    output logic      [IW-1:0]               o_mem_raddr,
    input  wire logic [ialt_pkg::ADDR_W-1:0] i_mem_rdata
);

    localparam int unsigned NW = CW + 1;

    ialt_pkg::t_state  r_state, n_state;
    ialt_pkg::t_action r_action, n_action;
    logic [ialt_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [IW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_count, n_count;
    ialt_pkg::t_status r_status, n_status;
    logic [IW-1:0]     r_ridx, n_ridx;
    logic              r_allowed, n_allowed;

    logic [NW-1:0] w_idx_p1;
    logic [NW-1:0] w_idx_p2;
    logic [NW-1:0] w_count_x;
    logic          w_hit;
    logic          w_invalid;
    logic [IW+ialt_pkg::EIDX_W-1:0] w_ridx_x;
    logic [CW+ialt_pkg::ECNT_W-1:0] w_count_o;

    assign w_idx_p1  = NW'(r_idx) + NW'(1);
    assign w_idx_p2  = NW'(r_idx) + NW'(2);
    assign w_count_x = NW'(r_count);
    assign w_hit     = (i_mem_rdata == r_addr);
    assign w_invalid = (i_req_addr == '0) || (i_req_addr == '1);

    // Fit index and count into the fixed response widths.
    assign w_ridx_x  = {{ialt_pkg::EIDX_W{1'b0}}, r_ridx};
    assign w_count_o = {{ialt_pkg::ECNT_W{1'b0}}, r_count};

    assign o_res.status      = r_status;
    assign o_res.entry_index = w_ridx_x[ialt_pkg::EIDX_W-1:0];
    assign o_res.allowed     = r_allowed;
    assign o_res.entry_count = w_count_o[ialt_pkg::ECNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ialt_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action  <= n_action;
        r_addr    <= n_addr;
        r_idx     <= n_idx;
        r_status  <= n_status;
        r_ridx    <= n_ridx;
        r_allowed <= n_allowed;
    end

    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_addr      = r_addr;
        n_idx       = r_idx;
        n_count     = r_count;
        n_status    = r_status;
        n_ridx      = r_ridx;
        n_allowed   = r_allowed;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx;
        o_mem_wdata = r_addr;
        o_mem_raddr = r_idx;

        unique case (r_state)
            ialt_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                o_mem_raddr = '0;
                if (i_req_valid) begin
                    n_action  = i_req_action;
                    n_addr    = i_req_addr;
                    n_idx     = '0;
                    n_status  = ialt_pkg::ST_OK;
                    n_ridx    = '0;
                    n_allowed = 1'b0;
                    if (i_req_action == ialt_pkg::ACT_CLEAR) begin
                        if (r_count == '0) begin
                            n_status = ialt_pkg::ST_NOT_FOUND;
                        end
                        n_count = '0;
                        n_state = ialt_pkg::S_RESP;
                    end else if (w_invalid && i_req_action != ialt_pkg::ACT_QUERY) begin
                        n_status = ialt_pkg::ST_INVALID;
                        n_state  = ialt_pkg::S_RESP;
                    end else if (r_count == '0) begin
                        n_state = ialt_pkg::S_MISS;
                    end else begin
                        n_state = ialt_pkg::S_SCAN;
                    end
                end
            end

            // Entry r_idx is on the read port; compare and fetch the next.
            ialt_pkg::S_SCAN: begin
                if (w_hit) begin
                    n_ridx = r_idx;
                    unique case (r_action)
                        ialt_pkg::ACT_ADD: begin
                            n_status = ialt_pkg::ST_PRESENT;
                            n_state  = ialt_pkg::S_RESP;
                        end
                        ialt_pkg::ACT_QUERY: begin
                            n_allowed = 1'b1;
                            n_state   = ialt_pkg::S_RESP;
                        end
                        ialt_pkg::ACT_REMOVE: begin
                            if (w_idx_p1 < w_count_x) begin
                                o_mem_raddr = w_idx_p1[IW-1:0];
                                n_state     = ialt_pkg::S_SHIFT;
                            end else begin
                                n_count = r_count - CW'(1);
                                n_state = ialt_pkg::S_RESP;
                            end
                        end
                        default: begin
                            n_state = ialt_pkg::S_RESP;
                        end
                    endcase
                end else if (w_idx_p1 < w_count_x) begin
                    o_mem_raddr = w_idx_p1[IW-1:0];
                    n_idx       = w_idx_p1[IW-1:0];
                end else begin
                    n_state = ialt_pkg::S_MISS;
                end
            end

            // Move entry r_idx+1 down to r_idx; fetch the one after.
            ialt_pkg::S_SHIFT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_idx;
                o_mem_wdata = i_mem_rdata;
                if (w_idx_p2 < w_count_x) begin
                    o_mem_raddr = w_idx_p2[IW-1:0];
                    n_idx       = w_idx_p1[IW-1:0];
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = ialt_pkg::S_RESP;
                end
            end

            // Address not stored: append, reject or report.
            ialt_pkg::S_MISS: begin
                n_state = ialt_pkg::S_RESP;
                unique case (r_action)
                    ialt_pkg::ACT_ADD: begin
                        if (r_count >= CW'(MAX_ENTRIES)) begin
                            n_status = ialt_pkg::ST_FULL;
                        end else begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = r_count[IW-1:0];
                            o_mem_wdata = r_addr;
                            n_count     = r_count + CW'(1);
                        end
                    end
                    ialt_pkg::ACT_REMOVE: begin
                        n_status = ialt_pkg::ST_NOT_FOUND;
                    end
                    default: begin
                        n_status = ialt_pkg::ST_OK;
                    end
                endcase
            end

            ialt_pkg::S_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = ialt_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ialt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/ip_allow_list_table_unit.sv
// Top level of the IPv4 allow list table: request port, sequencer, memory, response register.
//
// The block keeps an ordered, duplicate-free list of up to MAX_ENTRIES IPv4
// addresses in a single-port-write, single-port-read synchronous memory.
// Each request carries an action in tuser (add, remove, clear all, query) and
// an address in tdata; each request produces exactly one response with a
// status, the matching entry index, an allowed flag and the entry count after
// the action. Requests are handled one at a time, and the memory read port
// sets the pace: a search reads one entry per cycle, and a remove then
// compacts the list by moving one entry per cycle. A clear, or an add or
// remove with an invalid address, goes straight to the response; an empty
// table skips the search; and a remove that hits starts the shift where
// the scan stops. The next request is accepted once the response has
// entered the output register.
// The response register lets the next request be accepted while the previous
// response still waits on m_axis_tready. No clearing pass is needed after
// reset: only entries below the count are ever read.
`default_nettype none

module ip_allow_list_table_unit #(
    parameter int unsigned MAX_ENTRIES = ialt_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] address
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] action
    // response
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [2:0] status, [6:3] entry_index,
                                             // [7] allowed, [12:8] entry_count
);

    localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned RW = $bits(ialt_pkg::t_result);

    logic                        w_res_valid;
    logic                        w_res_take;
    ialt_pkg::t_result           w_res;
    logic                        w_mem_we;
    logic [IW-1:0]               w_mem_waddr;
    logic [ialt_pkg::ADDR_W-1:0] w_mem_wdata;
    logic [IW-1:0]               w_mem_raddr;
    logic [ialt_pkg::ADDR_W-1:0] w_mem_rdata;

    logic              r_out_valid;
    ialt_pkg::t_result r_out;

    ialt_seq #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IW          (IW),
        .CW          (CW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .o_req_ready  (s_axis_tready),
        .i_req_action (ialt_pkg::t_action'(s_axis_tuser)),
        .i_req_addr   (s_axis_tdata),
        .o_res_valid  (w_res_valid),
        .i_res_take   (w_res_take),
        .o_res        (w_res),
        .o_mem_we     (w_mem_we),
        .o_mem_waddr  (w_mem_waddr),
        .o_mem_wdata  (w_mem_wdata),
        .o_mem_raddr  (w_mem_raddr),
        .i_mem_rdata  (w_mem_rdata)
    );

    ialt_entry_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // Load the response register when it is empty or being drained.
    assign w_res_take = w_res_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(16 - RW)'(0), r_out};

endmodule

`default_nettype wire
